@@ design/fra_pkg.sv @@
// Shared constants, codes and the queue entry type for the fraction unit.
// Depends on nothing; every other file of the block refers to it by scope.
package fra_pkg;

    // operand width, products and reduction datapath follow from it
    localparam int OPW       = 16;
    localparam int PROD_W    = 2 * OPW;
    localparam int CNT_W     = $clog2(PROD_W);
    localparam int RES_NUM_W = 33;
    localparam int RES_DEN_W = 31;

    // operation codes
    localparam logic [1:0] FUNC_ADD = 2'd0;
    localparam logic [1:0] FUNC_SUB = 2'd1;
    localparam logic [1:0] FUNC_MUL = 2'd2;
    localparam logic [1:0] FUNC_DIV = 2'd3;

    // one classified beat, sign-magnitude operands
    typedef struct packed {
        logic [1:0]     op;
        logic           err;
        logic           an_neg;
        logic [OPW-1:0] an_mag;
        logic           ad_neg;
        logic [OPW-1:0] ad_mag;
        logic           bn_neg;
        logic [OPW-1:0] bn_mag;
        logic           bd_neg;
        logic [OPW-1:0] bd_mag;
    } t_item;

endpackage

@@ design/fra_if.sv @@
// Valid/ready channel interfaces for the fraction unit's input and result beats.
// Depends on fra_pkg for the operand widths.
interface fra_in_if;
    logic                          valid;
    logic                          ready;
    logic [1:0]                    func;
    logic signed [fra_pkg::OPW-1:0] a_num;
    logic signed [fra_pkg::OPW-1:0] a_den;
    logic signed [fra_pkg::OPW-1:0] b_num;
    logic signed [fra_pkg::OPW-1:0] b_den;
    modport source(output valid, func, a_num, a_den, b_num, b_den, input ready);
    modport sink(input valid, func, a_num, a_den, b_num, b_den, output ready);
endinterface

interface fra_out_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [fra_pkg::RES_NUM_W-1:0] res_num;
    logic [fra_pkg::RES_DEN_W-1:0]        res_den;
    logic                                 err;
    modport source(output valid, res_num, res_den, err, input ready);
    modport sink(input valid, res_num, res_den, err, output ready);
endinterface

@@ design/fra_front.sv @@
// Front end: accepts input beats, splits operands into sign and magnitude,
// flags zero denominators and division by zero. Depends on fra_pkg, fra_if.
module fra_front (
    fra_in_if.sink          i_in,
    input  logic            i_q_full,
    output logic            o_push,
    output fra_pkg::t_item  o_item
);

    function automatic logic [fra_pkg::OPW:0] take_op(input logic [fra_pkg::OPW-1:0] v);
        logic neg;
        neg = v[fra_pkg::OPW-1];
        take_op = {neg, neg ? (~v + 1'b1) : v};
    endfunction

    logic [fra_pkg::OPW:0] w_an, w_ad, w_bn, w_bd;

    assign i_in.ready = !i_q_full;
    assign o_push     = i_in.valid && !i_q_full;

    assign w_an = take_op(i_in.a_num);
    assign w_ad = take_op(i_in.a_den);
    assign w_bn = take_op(i_in.b_num);
    assign w_bd = take_op(i_in.b_den);

    // classify the beat
    always_comb begin
        o_item.op     = i_in.func;
        o_item.an_neg = w_an[fra_pkg::OPW];
        o_item.an_mag = w_an[fra_pkg::OPW-1:0];
        o_item.ad_neg = w_ad[fra_pkg::OPW];
        o_item.ad_mag = w_ad[fra_pkg::OPW-1:0];
        o_item.bn_neg = w_bn[fra_pkg::OPW];
        o_item.bn_mag = w_bn[fra_pkg::OPW-1:0];
        o_item.bd_neg = w_bd[fra_pkg::OPW];
        o_item.bd_mag = w_bd[fra_pkg::OPW-1:0];
        o_item.err    = (w_ad[fra_pkg::OPW-1:0] == '0) || (w_bd[fra_pkg::OPW-1:0] == '0) ||
                        ((i_in.func == fra_pkg::FUNC_DIV) && (w_bn[fra_pkg::OPW-1:0] == '0));
    end

endmodule

@@ design/fra_queue.sv @@
// Two-entry queue between front and back end.
// Depends on fra_pkg for the entry type.
module fra_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  fra_pkg::t_item i_item,
    output logic           o_full,
    output logic           o_valid,
    input  logic           i_pop,
    output fra_pkg::t_item o_item
);

    fra_pkg::t_item r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;

    assign o_full  = (r_count == 2'd2);
    assign o_valid = (r_count != 2'd0);
    assign o_item  = r_mem[r_rd_ptr];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ design/fra_back.sv @@
// Back end: shared multiplier, sign-magnitude add, binary GCD and a pair of
// restoring dividers that reduce the fraction. Depends on fra_pkg, fra_if.
module fra_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_q_valid,
    input  fra_pkg::t_item i_item,
    output logic           o_pop,
    fra_out_if.source      o_out
);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_MUL  = 6'b000010,
        S_ADD  = 6'b000100,
        S_GCD  = 6'b001000,
        S_DIV  = 6'b010000,
        S_OUT  = 6'b100000
    } t_state;

    localparam int PW = fra_pkg::PROD_W;

    t_state                      r_state, n_state;
    fra_pkg::t_item              r_item;
    logic [1:0]                  r_step;
    logic [PW-1:0]               r_p0, r_p1, r_dm, r_nm;
    logic                        r_s0, r_s1, r_sd, r_neg;
    logic [PW-1:0]               r_u, r_v, r_g;
    logic [fra_pkg::CNT_W-1:0]   r_k, r_cnt;
    logic [PW-1:0]               r_qn, r_qd, r_rn, r_rd;
    logic signed [fra_pkg::RES_NUM_W-1:0] r_res_num;
    logic [fra_pkg::RES_DEN_W-1:0]        r_res_den;
    logic                        r_err;

    logic [fra_pkg::OPW-1:0]     w_mx, w_my;
    logic                        w_ms;
    logic [PW-1:0]               w_prod;
    logic [PW-1:0]               w_num;
    logic                        w_nneg;
    logic [PW:0]                 w_shn, w_shd;
    logic                        w_gen, w_ged;
    logic [PW-1:0]               w_qn, w_qd;

    assign o_pop         = (r_state == S_IDLE) && i_q_valid;
    assign o_out.valid   = (r_state == S_OUT);
    assign o_out.res_num = r_res_num;
    assign o_out.res_den = r_res_den;
    assign o_out.err     = r_err;

    // operand select for the shared multiplier
    always_comb begin
        w_mx = r_item.ad_mag;
        w_my = r_item.bd_mag;
        w_ms = r_item.ad_neg ^ r_item.bd_neg;
        case (r_step)
            2'd0: begin
                w_mx = r_item.an_mag;
                w_my = (r_item.op == fra_pkg::FUNC_MUL) ? r_item.bn_mag : r_item.bd_mag;
                w_ms = r_item.an_neg ^
                       ((r_item.op == fra_pkg::FUNC_MUL) ? r_item.bn_neg : r_item.bd_neg);
            end
            2'd1: begin
                w_mx = r_item.bn_mag;
                w_my = r_item.ad_mag;
                w_ms = r_item.bn_neg ^ r_item.ad_neg ^ (r_item.op == fra_pkg::FUNC_SUB);
            end
            default: begin
                w_mx = r_item.ad_mag;
                w_my = (r_item.op == fra_pkg::FUNC_DIV) ? r_item.bn_mag : r_item.bd_mag;
                w_ms = r_item.ad_neg ^
                       ((r_item.op == fra_pkg::FUNC_DIV) ? r_item.bn_neg : r_item.bd_neg);
            end
        endcase
    end

    assign w_prod = PW'(w_mx) * PW'(w_my);

    // sign-magnitude sum of the two cross products
    always_comb begin
        if (r_s0 == r_s1) begin
            w_num  = r_p0 + r_p1;
            w_nneg = r_s0;
        end else if (r_p0 >= r_p1) begin
            w_num  = r_p0 - r_p1;
            w_nneg = r_s0;
        end else begin
            w_num  = r_p1 - r_p0;
            w_nneg = r_s1;
        end
    end

    // one restoring step for numerator and denominator against the GCD
    assign w_shn = {r_rn, r_qn[PW-1]};
    assign w_shd = {r_rd, r_qd[PW-1]};
    assign w_gen = (w_shn >= {1'b0, r_g});
    assign w_ged = (w_shd >= {1'b0, r_g});
    assign w_qn  = {r_qn[PW-2:0], w_gen};
    assign w_qd  = {r_qd[PW-2:0], w_ged};

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_q_valid) n_state = i_item.err ? S_OUT : S_MUL;
            S_MUL:  if (r_step == 2'd2) n_state = S_ADD;
            S_ADD:  n_state = (w_num == '0) ? S_OUT : S_GCD;
            S_GCD:  if (r_u == r_v) n_state = S_DIV;
            S_DIV:  if (r_cnt == fra_pkg::CNT_W'(PW - 1)) n_state = S_OUT;
            S_OUT:  if (o_out.ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_state <= S_IDLE;
        else          r_state <= n_state;
    end

    // datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_item <= i_item;
                r_step <= 2'd0;
                r_res_num <= '0;
                r_res_den <= '0;
                r_err     <= 1'b1;
            end
            S_MUL: begin
                r_step <= r_step + 2'd1;
                case (r_step)
                    2'd0: begin
                        r_p0 <= w_prod;
                        r_s0 <= w_ms;
                    end
                    2'd1: begin
                        if (r_item.op == fra_pkg::FUNC_ADD || r_item.op == fra_pkg::FUNC_SUB) begin
                            r_p1 <= w_prod;
                            r_s1 <= w_ms;
                        end else begin
                            r_p1 <= '0;
                            r_s1 <= 1'b0;
                        end
                    end
                    default: begin
                        r_dm <= w_prod;
                        r_sd <= w_ms;
                    end
                endcase
            end
            S_ADD: begin
                r_nm  <= w_num;
                r_neg <= w_nneg ^ r_sd;
                r_u   <= w_num;
                r_v   <= r_dm;
                r_k   <= '0;
                r_res_num <= '0;
                r_res_den <= fra_pkg::RES_DEN_W'(1);
                r_err     <= 1'b0;
            end
            S_GCD: begin
                if (r_u == r_v) begin
                    r_g   <= r_u << r_k;
                    r_qn  <= r_nm;
                    r_qd  <= r_dm;
                    r_rn  <= '0;
                    r_rd  <= '0;
                    r_cnt <= '0;
                end else if (!r_u[0] && !r_v[0]) begin
                    r_u <= r_u >> 1;
                    r_v <= r_v >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (r_u > r_v) begin
                    r_u <= r_u - r_v;
                end else begin
                    r_v <= r_v - r_u;
                end
            end
            S_DIV: begin
                r_cnt <= r_cnt + 1'b1;
                r_qn  <= w_qn;
                r_qd  <= w_qd;
                r_rn  <= w_gen ? PW'(w_shn - {1'b0, r_g}) : PW'(w_shn);
                r_rd  <= w_ged ? PW'(w_shd - {1'b0, r_g}) : PW'(w_shd);
                r_res_num <= r_neg ? -fra_pkg::RES_NUM_W'(w_qn) : fra_pkg::RES_NUM_W'(w_qn);
                r_res_den <= fra_pkg::RES_DEN_W'(w_qd);
                r_err     <= 1'b0;
            end
            default: begin
            end
        endcase
    end

`ifndef SYNTHESIS
    a_gcd_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_GCD) |-> (r_u != '0 && r_v != '0))
        else $error("gcd operand reached zero");
    a_div_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rn < r_g && r_rd < r_g))
        else $error("divider remainder not below gcd");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.err) |-> (o_out.res_num == '0 && o_out.res_den == '0))
        else $error("error result not 0/0");
    a_den_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && !o_out.err) |-> (o_out.res_den != '0))
        else $error("zero denominator without error");
`endif

endmodule

@@ design/fraction_arith_reduce_core.sv @@
// Top level of the fraction arithmetic unit with GCD reduction.
// Depends on fra_pkg, fra_if, fra_front, fra_queue and fra_back.
//
//  channel  dir  beat contents                          handshake
//  i_in     in   func, a_num, a_den, b_num, b_den       valid/ready
//  o_out    out  res_num, res_den, err                  valid/ready
//
// A beat is popped, has its cross products and denominator product formed on the
// shared 16x16 multiplier, is added, runs the binary GCD loop, then the pair of
// restoring dividers, and is presented on o_out, where it may stall.
// Error beats go from the pop straight to presenting, zero numerators from the add.
// Reset is synchronous, active low, and empties the queue and the sequencer.
// The two-entry queue keeps accepting beats, until it is full, while a result waits on o_out.
module fraction_arith_reduce_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    fra_in_if.sink      i_in,
    fra_out_if.source   o_out
);

    logic           w_push, w_full, w_qvalid, w_pop;
    fra_pkg::t_item w_in_item, w_q_item;

    fra_front u_front (
        .i_in     (i_in),
        .i_q_full (w_full),
        .o_push   (w_push),
        .o_item   (w_in_item)
    );

    fra_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_in_item),
        .o_full  (w_full),
        .o_valid (w_qvalid),
        .i_pop   (w_pop),
        .o_item  (w_q_item)
    );

    fra_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (w_qvalid),
        .i_item    (w_q_item),
        .o_pop     (w_pop),
        .o_out     (o_out)
    );

endmodule
